[hdl/aat_pkg.sv]
// shared types, constants and helpers for the box transform core
package aat_pkg;

	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * COORD_W;
	localparam int NUM_AXES = 3;
	// three products summed need two more bits
	localparam int SUM_W    = PROD_W + 2;
	// floored sum plus translation
	localparam int ACC_W    = SUM_W - FRAC_W + 1;

	localparam int CFG_W        = 64;
	localparam int NUM_REGS     = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int REGS_PER_ROW = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [CFG_W-1:0]          cfg_word_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_ROW0_COLS01 = 3'd0;
	localparam cfg_idx_t REG_ROW0_COLS23 = 3'd1;
	localparam cfg_idx_t REG_ROW1_COLS01 = 3'd2;
	localparam cfg_idx_t REG_ROW1_COLS23 = 3'd3;
	localparam cfg_idx_t REG_ROW2_COLS01 = 3'd4;
	localparam cfg_idx_t REG_ROW2_COLS23 = 3'd5;

	localparam cfg_word_t ONE_Q16 = cfg_word_t'(1) << FRAC_W;

	// identity matrix
	localparam cfg_word_t REG_RESET [NUM_REGS] = '{
		ONE_Q16,
		'0,
		ONE_Q16 << COORD_W,
		'0,
		'0,
		ONE_Q16
	};

	// per stage load enables handed to the datapath
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	function automatic coord_t sat_coord(input acc_t v);
		logic [ACC_W-COORD_W:0] top;
		top = v[ACC_W-1:COORD_W-1];
		if ((&top) || !(|top)) begin
			return v[COORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

[hdl/aat_in_if.sv]
// input box channel
interface aat_in_if;
	logic valid;
	logic ready;
	aat_pkg::coord_t in_min_x;
	aat_pkg::coord_t in_min_y;
	aat_pkg::coord_t in_min_z;
	aat_pkg::coord_t in_max_x;
	aat_pkg::coord_t in_max_y;
	aat_pkg::coord_t in_max_z;

	modport source (
		output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
		input ready
	);
	modport sink (
		input valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
		output ready
	);
endinterface

[hdl/aat_out_if.sv]
// result box channel
interface aat_out_if;
	logic valid;
	logic ready;
	aat_pkg::coord_t out_min_x;
	aat_pkg::coord_t out_min_y;
	aat_pkg::coord_t out_min_z;
	aat_pkg::coord_t out_max_x;
	aat_pkg::coord_t out_max_y;
	aat_pkg::coord_t out_max_z;

	modport source (
		output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		input ready
	);
	modport sink (
		input valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		output ready
	);
endinterface

[hdl/aat_row.sv]
// four stage datapath for one output axis: products, per column min/max, sum, floor and saturate
module aat_row (
	input  logic              clk,
	input  aat_pkg::pipe_en_t en,
	input  aat_pkg::coord_t   coef [aat_pkg::NUM_AXES],
	input  aat_pkg::coord_t   trans,
	input  aat_pkg::coord_t   lo [aat_pkg::NUM_AXES],
	input  aat_pkg::coord_t   hi [aat_pkg::NUM_AXES],
	output aat_pkg::coord_t   res_min,
	output aat_pkg::coord_t   res_max
);

	aat_pkg::prod_t  p_lo_s1 [aat_pkg::NUM_AXES];
	aat_pkg::prod_t  p_hi_s1 [aat_pkg::NUM_AXES];
	aat_pkg::prod_t  t_min_s2 [aat_pkg::NUM_AXES];
	aat_pkg::prod_t  t_max_s2 [aat_pkg::NUM_AXES];
	aat_pkg::sum_t   sum_min_s3;
	aat_pkg::sum_t   sum_max_s3;
	aat_pkg::coord_t res_min_s4;
	aat_pkg::coord_t res_max_s4;
	aat_pkg::acc_t   acc_min;
	aat_pkg::acc_t   acc_max;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
				p_lo_s1[i] <= aat_pkg::prod_t'(coef[i]) * aat_pkg::prod_t'(lo[i]);
				p_hi_s1[i] <= aat_pkg::prod_t'(coef[i]) * aat_pkg::prod_t'(hi[i]);
			end
		end
	end

	// each term is separable, so the corner extremes are sums of per column extremes
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
				t_min_s2[i] <= (p_lo_s1[i] < p_hi_s1[i]) ? p_lo_s1[i] : p_hi_s1[i];
				t_max_s2[i] <= (p_lo_s1[i] < p_hi_s1[i]) ? p_hi_s1[i] : p_lo_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_min_s3 <= aat_pkg::sum_t'(t_min_s2[0]) + aat_pkg::sum_t'(t_min_s2[1])
				+ aat_pkg::sum_t'(t_min_s2[2]);
			sum_max_s3 <= aat_pkg::sum_t'(t_max_s2[0]) + aat_pkg::sum_t'(t_max_s2[1])
				+ aat_pkg::sum_t'(t_max_s2[2]);
		end
	end

	// dropping the fraction bits of a signed value floors it
	always_comb begin
		acc_min = aat_pkg::acc_t'($signed(sum_min_s3[aat_pkg::SUM_W-1:aat_pkg::FRAC_W]))
			+ aat_pkg::acc_t'(trans);
		acc_max = aat_pkg::acc_t'($signed(sum_max_s3[aat_pkg::SUM_W-1:aat_pkg::FRAC_W]))
			+ aat_pkg::acc_t'(trans);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_min_s4 <= aat_pkg::sat_coord(acc_min);
			res_max_s4 <= aat_pkg::sat_coord(acc_max);
		end
	end

	assign res_min = res_min_s4;
	assign res_max = res_max_s4;

endmodule

[hdl/aabb_affine_transform_core.sv]
// 4 register stages: products, column min/max, sum, floor and saturate
// throughput: one box per cycle when the output is not stalled
// each stage moves when the one after it is empty or moving, so bubbles collapse under stall
// 18 signed 32x32 multipliers in stage one set the critical path
// reset clears all stage valid bits and loads the identity matrix; no clearing pass
module aabb_affine_transform_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  aat_pkg::cfg_idx_t   cfg_idx,
	input  aat_pkg::cfg_word_t  cfg_wdata,
	aat_in_if.sink              box,
	aat_out_if.source           result
);

	aat_pkg::cfg_word_t coef_q [aat_pkg::NUM_REGS];

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	aat_pkg::pipe_en_t en;

	aat_pkg::coord_t lo [aat_pkg::NUM_AXES];
	aat_pkg::coord_t hi [aat_pkg::NUM_AXES];
	aat_pkg::coord_t res_min [aat_pkg::NUM_AXES];
	aat_pkg::coord_t res_max [aat_pkg::NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < aat_pkg::NUM_REGS; r++) begin
				coef_q[r] <= aat_pkg::REG_RESET[r];
			end
		end else if (cfg_we && (cfg_idx <= aat_pkg::REG_ROW2_COLS23)) begin
			coef_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_comb begin
		rdy4 = !v_s4 || result.ready;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		en.s1 = rdy1 && box.valid;
		en.s2 = rdy2 && v_s1;
		en.s3 = rdy3 && v_s2;
		en.s4 = rdy4 && v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= box.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign box.ready    = rdy1;
	assign result.valid = v_s4;

	assign lo[0] = box.in_min_x;
	assign lo[1] = box.in_min_y;
	assign lo[2] = box.in_min_z;
	assign hi[0] = box.in_max_x;
	assign hi[1] = box.in_max_y;
	assign hi[2] = box.in_max_z;

	for (genvar a = 0; a < aat_pkg::NUM_AXES; a++) begin : g_row
		aat_pkg::coord_t row_coef [aat_pkg::NUM_AXES];
		aat_pkg::coord_t row_trans;

		// low half col 0 or 2, high half col 1 or translation
		assign row_coef[0] = coef_q[aat_pkg::REGS_PER_ROW*a][aat_pkg::COORD_W-1:0];
		assign row_coef[1] = coef_q[aat_pkg::REGS_PER_ROW*a][aat_pkg::CFG_W-1:aat_pkg::COORD_W];
		assign row_coef[2] = coef_q[aat_pkg::REGS_PER_ROW*a+1][aat_pkg::COORD_W-1:0];
		assign row_trans   = coef_q[aat_pkg::REGS_PER_ROW*a+1][aat_pkg::CFG_W-1:aat_pkg::COORD_W];

		aat_row u_row (
			.clk     (clk),
			.en      (en),
			.coef    (row_coef),
			.trans   (row_trans),
			.lo      (lo),
			.hi      (hi),
			.res_min (res_min[a]),
			.res_max (res_max[a])
		);
	end

	assign result.out_min_x = res_min[0];
	assign result.out_min_y = res_min[1];
	assign result.out_min_z = res_min[2];
	assign result.out_max_x = res_max[0];
	assign result.out_max_y = res_max[1];
	assign result.out_max_z = res_max[2];

	// a result held at the output stays until its transfer
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !result.ready) |=> v_s4)
		else $error("result dropped while stalled");

	// a full, stalled pipeline takes no new box
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !result.ready) |-> !box.ready)
		else $error("box accepted into full pipeline");

	// an accepted box lands in stage one
	a_input_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(box.valid && box.ready) |=> v_s1)
		else $error("accepted box lost at stage one");

	// min and max are monotone in the column extremes, so the box is never inverted
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.out_min_x <= result.out_max_x)
			&& (result.out_min_y <= result.out_max_y)
			&& (result.out_min_z <= result.out_max_z)))
		else $error("result min exceeds max");

endmodule
